// ===== rtl/core/tlrg_pkg.sv =====
// thin lens ray generator package: payload structs, cell state, constants
// no dependencies

package tlrg_pkg;

	localparam int COORD_W = 16;
	localparam int OUT_W = 20;
	localparam int STEPS = 16;
	localparam int XW = 34;
	localparam int REMW = 20;

	localparam logic [2:0] REG_EYE = 3'd0;
	localparam logic [2:0] REG_UP = 3'd1;
	localparam logic [2:0] REG_SIDE = 3'd2;
	localparam logic [2:0] REG_FILM = 3'd3;
	localparam logic [2:0] REG_LENS = 3'd4;

	localparam logic signed [XW-1:0] GAIN_INV = XW'(64'h26DD3B6A);

	typedef logic signed [XW-1:0] atan_tab_t [STEPS];
	localparam atan_tab_t ATAN_TURN = '{
		XW'(64'h20000000), XW'(64'h12E4051E), XW'(64'h09FB385B), XW'(64'h051111D4),
		XW'(64'h028B0D43), XW'(64'h0145D7E1), XW'(64'h00A2F61E), XW'(64'h00517C55),
		XW'(64'h0028BE53), XW'(64'h00145F2F), XW'(64'h000A2F98), XW'(64'h000517CC),
		XW'(64'h00028BE6), XW'(64'h000145F3), XW'(64'h0000A2FA), XW'(64'h0000517D)
	};

	typedef struct packed {
		logic signed [COORD_W-1:0] image_x;
		logic signed [COORD_W-1:0] image_y;
		logic [15:0] lens_angle_sample;
		logic [15:0] lens_radius_sample;
	} ray_req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] org_x;
		logic signed [OUT_W-1:0] org_y;
		logic signed [OUT_W-1:0] org_z;
		logic signed [OUT_W-1:0] dir_x;
		logic signed [OUT_W-1:0] dir_y;
		logic signed [OUT_W-1:0] dir_z;
	} ray_rsp_t;

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [15:0] root;
		logic [31:0] rad;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [XW-1:0] z;
		logic [1:0] quad;
		logic signed [COORD_W-1:0] ix;
		logic signed [COORD_W-1:0] iy;
	} cell_t;

endpackage

// ===== rtl/core/thin_lens_ray_generator_top.sv =====
// thin lens ray generator top: 16-cell sqrt/cordic chain and product stages
// 20 register stages: the 16 cells, then stages 1 to 3 and the output register
// one request per cycle sustained while the output is not held, set by the one-rotation-per-cell chain
// the 16 cells each retire one root digit and one cordic rotation per cycle while advancing
// the whole pipeline holds while a finished result waits and out_ready is low
// arst_n clears all valid flags and the configuration registers to zero
// depends on tlrg_pkg and tlrg_cell

module thin_lens_ray_generator_top import tlrg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ray_req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ray_rsp_t out_data,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_data
);

	localparam int IMG_SH = COORD_W - 17;
	localparam int IMG_RSH = (IMG_SH >= 0) ? IMG_SH : 0;
	localparam int IMG_LSH = (IMG_SH < 0) ? -IMG_SH : 0;
	localparam int SW = (OUT_W + 17 > 48) ? OUT_W + 17 : 48;
	localparam int RW = SW - 16;

	// configuration registers
	logic [47:0] eye_q, up_q, side_q, film_q;
	logic [15:0] lens_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_q <= '0;
			up_q <= '0;
			side_q <= '0;
			film_q <= '0;
			lens_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EYE: eye_q <= cfg_data;
				REG_UP: up_q <= cfg_data;
				REG_SIDE: side_q <= cfg_data;
				REG_FILM: film_q <= cfg_data;
				REG_LENS: lens_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// global advance: everything moves unless a result is stuck at the output
	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// chain entry: quadrant fold and cordic seed
	cell_t head;
	logic [15:0] a_rnd;
	logic [1:0] quad;
	logic [15:0] dlt;

	always_comb begin
		a_rnd = in_data.lens_angle_sample + 16'h2000;
		quad = a_rnd[15:14];
		dlt = in_data.lens_angle_sample - {quad, 14'd0};
		head.rem = '0;
		head.root = '0;
		head.rad = {in_data.lens_radius_sample, 16'd0};
		head.x = GAIN_INV;
		head.y = '0;
		head.z = {{(XW-32){dlt[15]}}, dlt, 16'd0};
		head.quad = quad;
		head.ix = in_data.image_x;
		head.iy = in_data.image_y;
	end

	logic vld_c [STEPS+1];
	cell_t dat_c [STEPS+1];
	assign vld_c[0] = in_valid;
	assign dat_c[0] = head;

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		tlrg_cell #(.IDX(g)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vld_in(vld_c[g]),
			.d_in(dat_c[g]),
			.vld_out(vld_c[g+1]),
			.d_out(dat_c[g+1])
		);
	end

	cell_t tail;
	assign tail = dat_c[STEPS];

	// stage 1: round cordic outputs, unfold quadrant, scale radius
	logic signed [XW-1:0] c_rnd, s_rnd;
	logic signed [17:0] c_v, s_v;
	logic signed [17:0] cos_s1, sin_s1;
	logic [31:0] r_s1;
	logic signed [COORD_W-1:0] ix_s1, iy_s1;
	logic v_s1;

	always_comb begin
		c_rnd = (tail.x + XW'(8192)) >>> 14;
		s_rnd = (tail.y + XW'(8192)) >>> 14;
		c_v = c_rnd[17:0];
		s_v = s_rnd[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_c[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (tail.quad)
				2'd0: begin cos_s1 <= c_v; sin_s1 <= s_v; end
				2'd1: begin cos_s1 <= -s_v; sin_s1 <= c_v; end
				2'd2: begin cos_s1 <= -c_v; sin_s1 <= -s_v; end
				default: begin cos_s1 <= s_v; sin_s1 <= -c_v; end
			endcase
			r_s1 <= lens_q * tail.root;
			ix_s1 <= tail.ix;
			iy_s1 <= tail.iy;
		end
	end

	// vector component k of a packed register, sign extended
	function automatic logic signed [15:0] comp(input logic [47:0] p, input int k);
		comp = p[16*k +: 16];
	endfunction

	// stage 2: lens radius times cos/sin, image products aligned to q.24
	logic signed [50:0] rcp, rsp;
	logic signed [27:0] rc_s2, rs_s2;
	logic signed [SW-1:0] imx_s2 [3];
	logic signed [SW-1:0] imy_s2 [3];
	logic signed [SW-1:0] px [3];
	logic signed [SW-1:0] py [3];
	logic v_s2;

	always_comb begin
		rcp = ($signed({1'b0, r_s1}) * cos_s1) + 51'sd8388608;
		rsp = ($signed({1'b0, r_s1}) * sin_s1) + 51'sd8388608;
		for (int k = 0; k < 3; k++) begin
			px[k] = SW'(ix_s1 * comp(side_q, k));
			py[k] = SW'(iy_s1 * comp(up_q, k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rc_s2 <= 28'(rcp >>> 24);
			rs_s2 <= 28'(rsp >>> 24);
			for (int k = 0; k < 3; k++) begin
				imx_s2[k] <= (px[k] <<< IMG_LSH) >>> IMG_RSH;
				imy_s2[k] <= (py[k] <<< IMG_LSH) >>> IMG_RSH;
			end
		end
	end

	// stage 3: lens offset per component, image term sum
	logic signed [SW-1:0] off_s3 [3];
	logic signed [SW-1:0] img_s3 [3];
	logic v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				off_s3[k] <= SW'(rc_s2 * comp(up_q, k)) + SW'(rs_s2 * comp(side_q, k));
				img_s3[k] <= imx_s2[k] + imy_s2[k];
			end
		end
	end

	// round to q.8 and saturate to the output range
	function automatic logic signed [OUT_W-1:0] finish(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		logic signed [RW-1:0] r;
		t = (v + SW'(32768)) >>> 16;
		r = t[RW-1:0];
		if (r > $signed(RW'({1'b0, {(OUT_W-1){1'b1}}})))
			finish = {1'b0, {(OUT_W-1){1'b1}}};
		else if (r < -$signed(RW'({1'b0, {(OUT_W-1){1'b1}}})) - RW'(1))
			finish = {1'b1, {(OUT_W-1){1'b0}}};
		else
			finish = r[OUT_W-1:0];
	endfunction

	// stage 4: origin and direction sums into the output register
	logic signed [SW-1:0] org [3];
	logic signed [SW-1:0] dir [3];
	ray_rsp_t rsp_n;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			org[k] = (SW'(comp(eye_q, k)) <<< 16) + off_s3[k];
			dir[k] = img_s3[k] + (SW'(comp(film_q, k)) <<< 16) - off_s3[k];
		end
		rsp_n.org_x = finish(org[0]);
		rsp_n.org_y = finish(org[1]);
		rsp_n.org_z = finish(org[2]);
		rsp_n.dir_x = finish(dir[0]);
		rsp_n.dir_y = finish(dir[1]);
		rsp_n.dir_z = finish(dir[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= rsp_n;
		end
	end

endmodule

// ===== rtl/core/tlrg_cell.sv =====
// one cell of the chain: a square root digit and a cordic rotation
// depends on tlrg_pkg

module tlrg_cell import tlrg_pkg::*; #(
	parameter int IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input cell_t d_in,
	output logic vld_out,
	output cell_t d_out
);

	cell_t nxt;
	logic [REMW-1:0] rem_sh;
	logic [REMW-1:0] test;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	always_comb begin
		nxt = d_in;
		// radicand digit pair from the top, radicand shifts along
		rem_sh = {d_in.rem[REMW-3:0], d_in.rad[31:30]};
		test = {{(REMW-18){1'b0}}, d_in.root, 2'b01};
		nxt.rad = {d_in.rad[29:0], 2'b00};
		if (rem_sh >= test) begin
			nxt.rem = rem_sh - test;
			nxt.root = {d_in.root[14:0], 1'b1};
		end else begin
			nxt.rem = rem_sh;
			nxt.root = {d_in.root[14:0], 1'b0};
		end
		dx = d_in.y >>> IDX;
		dy = d_in.x >>> IDX;
		if (!d_in.z[XW-1]) begin
			nxt.x = d_in.x - dx;
			nxt.y = d_in.y + dy;
			nxt.z = d_in.z - ATAN_TURN[IDX];
		end else begin
			nxt.x = d_in.x + dx;
			nxt.y = d_in.y - dy;
			nxt.z = d_in.z + ATAN_TURN[IDX];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule
